// ===== hdl/timestamp_ordered_multi_fifo_top_macros.svh =====
// Assertion helpers shared by the block's RTL files.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef TIMESTAMP_ORDERED_MULTI_FIFO_TOP_MACROS_SVH
`define TIMESTAMP_ORDERED_MULTI_FIFO_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOMF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TOMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tomf_pkg.sv =====
`default_nettype none

package tomf_pkg;

  // Store geometry.
  localparam int NUM_SOURCES = 8;
  localparam int FIFO_DEPTH  = 16;
  localparam int SLOTS       = NUM_SOURCES * FIFO_DEPTH;

  localparam int SIDX_W  = $clog2(NUM_SOURCES);
  localparam int SCAN_W  = $clog2(NUM_SOURCES + 1);
  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W  = $clog2(SLOTS);
  localparam int GRAND_W = $clog2(SLOTS + 1);

  // Field widths of the transfers.
  localparam int FUNC_W  = 2;
  localparam int SRC_W   = 3;
  localparam int STAMP_W = 64;
  localparam int PAY_W   = 32;
  localparam int STS_W   = 2;
  localparam int TOT_W   = 8;
  localparam int ENTRY_W = STAMP_W + PAY_W;

  localparam int IN_DATA_W  = 8 * ((SRC_W + STAMP_W + PAY_W + 7) / 8);
  localparam int OUT_DATA_W = 8 * ((SRC_W + STAMP_W + PAY_W + TOT_W + 7) / 8);
  localparam int OUT_USER_W = STS_W + 1;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SIDX_W-1:0] sidx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Circular pointer increment.
  function automatic ptr_t ptr_adv(input ptr_t ptr);
    ptr_t res;
    if (ptr == PTR_W'(FIFO_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + 1'b1;
    end
    return res;
  endfunction

  // Flat store address of one source's entry.
  function automatic addr_t slot_addr(input sidx_t idx, input ptr_t ptr);
    return ADDR_W'(idx) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(ptr);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tomf_ram.sv =====
`default_nettype none

module tomf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/timestamp_ordered_multi_fifo_top.sv =====
// Channel  Direction  Ports                     Contents
// in_      slave      tvalid tready tdata tuser one operation (push, pop or clear)
// out_     master     tvalid tready tdata tuser exactly one result per operation
//
// A push, clear or unused code goes straight to the final state; a pop first runs a scan
// reading each non-empty head through one RAM port into one 64-bit comparator.
// in_tready is high only when idle; a finished result waits in the output register while
// the next operation is taken, and the final state stalls until that register is free.
// Reset (rst_n low, synchronous) empties every FIFO; the entry RAM is not cleared.
`default_nettype none

module timestamp_ordered_multi_fifo_top
  import tomf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // source_id [2:0], stamp [66:3], payload [98:67], zero fill above
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // func [1:0]
  input  wire logic [FUNC_W-1:0]     in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_source [2:0], out_stamp [66:3], out_payload [98:67],
  // total_entries [106:99], zero fill above
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // status [1:0], out_valid [2]
  output logic [OUT_USER_W-1:0]      out_tuser
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // Control state.
  logic [1:0]         state_r, state_nxt;
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [SCAN_W-1:0]  scan_r, scan_nxt;
  logic               rd_v_r, rd_v_nxt;
  sidx_t              rd_src_r, rd_src_nxt;
  logic               found_r, found_nxt;
  sidx_t              best_r, best_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  ptr_t               rp_r [NUM_SOURCES];
  ptr_t               rp_nxt [NUM_SOURCES];
  ptr_t               wp_r [NUM_SOURCES];
  ptr_t               wp_nxt [NUM_SOURCES];
  cnt_t               fill_r [NUM_SOURCES];
  cnt_t               fill_nxt [NUM_SOURCES];
  logic [GRAND_W-1:0] grand_r, grand_nxt;

  // Payload state, no reset needed.
  logic [SRC_W-1:0]   src_r, src_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [PAY_W-1:0]   pay_r, pay_nxt;
  logic [STAMP_W-1:0] best_stamp_r, best_stamp_nxt;
  logic [PAY_W-1:0]   best_pay_r, best_pay_nxt;
  logic [STS_W-1:0]   o_sts_r;
  logic               o_rv_r;
  logic [SRC_W-1:0]   o_src_r;
  logic [STAMP_W-1:0] o_stamp_r;
  logic [PAY_W-1:0]   o_pay_r;
  logic [TOT_W-1:0]   o_tot_r;

  // Result being formed in the final state.
  logic               res_load;
  logic [STS_W-1:0]   res_sts;
  logic               res_rv;
  logic [SRC_W-1:0]   res_src;
  logic [STAMP_W-1:0] res_stamp;
  logic [PAY_W-1:0]   res_pay;

  // Entry RAM port signals.
  logic               ram_we;
  logic               ram_re;
  addr_t              ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [STAMP_W-1:0] head_stamp;
  logic [PAY_W-1:0]   head_pay;

  // One source is looked at per cycle: the scanned one during a pop scan,
  // otherwise the pushed source or the pop winner.
  sidx_t              sel_idx;
  ptr_t               rp_sel;
  ptr_t               wp_sel;
  cnt_t               fill_sel;
  logic               in_xfer;

  assign in_tready  = rst_n && (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign head_stamp = ram_rdata[STAMP_W-1:0];
  assign head_pay   = ram_rdata[ENTRY_W-1:STAMP_W];

  always_comb begin
    if (state_r == ST_SCAN) begin
      sel_idx = scan_r[SIDX_W-1:0];
    end else if (func_r == FN_PUSH) begin
      sel_idx = SIDX_W'(src_r);
    end else begin
      sel_idx = best_r;
    end
  end

  assign rp_sel    = rp_r[sel_idx];
  assign wp_sel    = wp_r[sel_idx];
  assign fill_sel  = fill_r[sel_idx];
  assign ram_raddr = slot_addr(sel_idx, rp_sel);

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    scan_nxt       = scan_r;
    rd_v_nxt       = rd_v_r;
    rd_src_nxt     = rd_src_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    out_tvalid_nxt = out_tvalid_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    fill_nxt       = fill_r;
    grand_nxt      = grand_r;
    src_nxt        = src_r;
    stamp_nxt      = stamp_r;
    pay_nxt        = pay_r;
    best_stamp_nxt = best_stamp_r;
    best_pay_nxt   = best_pay_r;
    res_load       = 1'b0;
    res_sts        = STS_OK;
    res_rv         = 1'b0;
    res_src        = '0;
    res_stamp      = '0;
    res_pay        = '0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          func_nxt  = in_tuser;
          src_nxt   = in_tdata[SRC_W-1:0];
          stamp_nxt = in_tdata[SRC_W+STAMP_W-1:SRC_W];
          pay_nxt   = in_tdata[SRC_W+STAMP_W+PAY_W-1:SRC_W+STAMP_W];
          scan_nxt  = '0;
          rd_v_nxt  = 1'b0;
          found_nxt = 1'b0;
          state_nxt = (in_tuser == FN_POP) ? ST_SCAN : ST_FIN;
        end
      end

      ST_SCAN: begin
        // Issue one head read per cycle; compare the head read last cycle.
        rd_v_nxt = 1'b0;
        if (scan_r < SCAN_W'(NUM_SOURCES)) begin
          scan_nxt = scan_r + 1'b1;
          if (fill_sel != '0) begin
            ram_re     = 1'b1;
            rd_v_nxt   = 1'b1;
            rd_src_nxt = scan_r[SIDX_W-1:0];
          end
        end
        // Strict compare in ascending source order keeps the lower source on ties.
        if (rd_v_r && (!found_r || (head_stamp < best_stamp_r))) begin
          found_nxt      = 1'b1;
          best_nxt       = rd_src_r;
          best_stamp_nxt = head_stamp;
          best_pay_nxt   = head_pay;
        end
        if ((scan_r == SCAN_W'(NUM_SOURCES)) && !rd_v_r) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        // State changes only once the result has a place to go.
        if (!out_tvalid_r || out_tready) begin
          res_load       = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
          case (func_r)
            FN_PUSH: begin
              if ((int'(src_r) >= NUM_SOURCES) || (fill_sel == CNT_W'(FIFO_DEPTH))) begin
                res_sts = STS_FULL;
              end else begin
                ram_we            = 1'b1;
                wp_nxt[sel_idx]   = ptr_adv(wp_sel);
                fill_nxt[sel_idx] = fill_sel + 1'b1;
                grand_nxt         = grand_r + 1'b1;
              end
            end
            FN_POP: begin
              if (!found_r) begin
                res_sts = STS_EMPTY;
              end else begin
                res_rv            = 1'b1;
                res_src           = SRC_W'(best_r);
                res_stamp         = best_stamp_r;
                res_pay           = best_pay_r;
                rp_nxt[sel_idx]   = ptr_adv(rp_sel);
                fill_nxt[sel_idx] = fill_sel - 1'b1;
                grand_nxt         = grand_r - 1'b1;
              end
            end
            FN_CLEAR: begin
              for (int i = 0; i < NUM_SOURCES; i++) begin
                rp_nxt[i]   = '0;
                wp_nxt[i]   = '0;
                fill_nxt[i] = '0;
              end
              grand_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      func_r       <= FN_PUSH;
      scan_r       <= '0;
      rd_v_r       <= 1'b0;
      rd_src_r     <= '0;
      found_r      <= 1'b0;
      best_r       <= '0;
      out_tvalid_r <= 1'b0;
      grand_r      <= '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        rp_r[i]   <= '0;
        wp_r[i]   <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      func_r       <= func_nxt;
      scan_r       <= scan_nxt;
      rd_v_r       <= rd_v_nxt;
      rd_src_r     <= rd_src_nxt;
      found_r      <= found_nxt;
      best_r       <= best_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      grand_r      <= grand_nxt;
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      fill_r       <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    stamp_r      <= stamp_nxt;
    pay_r        <= pay_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_pay_r   <= best_pay_nxt;
    if (res_load) begin
      o_sts_r   <= res_sts;
      o_rv_r    <= res_rv;
      o_src_r   <= res_src;
      o_stamp_r <= res_stamp;
      o_pay_r   <= res_pay;
      o_tot_r   <= TOT_W'(grand_nxt);
    end
  end

  // Entry RAM: payload in the upper bits, timestamp in the lower bits.
  tomf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_addr(sel_idx, wp_sel)),
    .wdata ({pay_r, stamp_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = {o_rv_r, o_sts_r};
  assign out_tdata  = {(OUT_DATA_W - SRC_W - STAMP_W - PAY_W - TOT_W)'(0),
                       o_tot_r, o_pay_r, o_stamp_r, o_src_r};

  `include "timestamp_ordered_multi_fifo_top_macros.svh"

  // An accepted operation always starts work.
  `TOMF_ASSERT_NEXT(a_xfer_starts, in_xfer, state_r != ST_IDLE, "accepted op left sequencer idle")
  // No new operation is taken during a pop scan.
  `TOMF_ASSERT_SAME(a_scan_busy, state_r == ST_SCAN, !in_tready, "ready during pop scan")
  // A new result only appears out of the final state.
  `TOMF_ASSERT_SAME(a_result_src, $rose(out_tvalid_r), $past(state_r) == ST_FIN, "result outside final state")
  // A delivered entry always carries an ok status.
  `TOMF_ASSERT_SAME(a_valid_ok, out_tvalid && out_tuser[STS_W], out_tuser[STS_W-1:0] == STS_OK, "delivered entry with error status")

endmodule

`default_nettype wire
